@@ hw/rtl/ludf_pkg.sv @@
package ludf_pkg;

    localparam int unsigned MAX_DIM_DEF = 8;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned SIZE_W      = 4;
    localparam int unsigned SIZE_RESET  = 8;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] element_value;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         column_index;
        logic signed [DATA_W-1:0] lower_value;
        logic signed [DATA_W-1:0] upper_value;
        logic                     pivot_fault;
        logic                     last_result;
    } t_out_req;

    // shared divider handshake
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } t_div_cmd;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648) sat32 = 32'sh8000_0000;
        else                           sat32 = v[DATA_W-1:0];
    endfunction

endpackage

@@ hw/rtl/ludf_stream_if.sv @@
interface ludf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ludf_div.sv @@
// Restoring divider: |num|<<16 / |den|, one quotient bit a cycle.
module ludf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ludf_pkg::t_div_cmd i_cmd,
    output ludf_pkg::t_div_rsp o_rsp
);
    import ludf_pkg::*;

    localparam int unsigned NUM_W = 48;
    localparam int unsigned CNT_W = 6;

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_q, n_q;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [DATA_W-1:0] r_den, n_den;
    logic              r_neg, n_neg;
    logic              r_done, n_done;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic signed [65:0] w_sq;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        w_shift = {r_rem[DATA_W-1:0], r_q[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_q    = {(i_cmd.num[DATA_W-1] ? DATA_W'(-i_cmd.num) : DATA_W'(i_cmd.num)),
                      16'h0};
            n_rem  = '0;
            n_den  = i_cmd.den[DATA_W-1] ? DATA_W'(-i_cmd.den) : DATA_W'(i_cmd.den);
            n_neg  = i_cmd.num[DATA_W-1] ^ i_cmd.den[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                n_rem = w_diff;
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    always_comb begin
        w_sq = r_neg ? -$signed({18'd0, r_q}) : $signed({18'd0, r_q});
        o_rsp.done = r_done;
        o_rsp.quot = sat32(w_sq);
    end
endmodule

@@ hw/rtl/lu_doolittle_factorizer_unit.sv @@
// Doolittle LU factorizer, no pivoting, signed Q16.16. Send n*n elements
// row-major (n = matrix_size, 0 acts as 1, above MAX_DIM as MAX_DIM); loading
// takes one element per cycle unless a size write is pending. After the last
// element the input stalls while one shared multiply-accumulate datapath
// works the factorization: entry and finish states per entry, read, multiply
// and accumulate states per term, a shift-subtract division per lower-factor
// entry. Then n*n results leave row-major via order and output states while
// the sink is ready. Size writes are taken only while loading and restart it.
module lu_doolittle_factorizer_unit #(
    parameter int unsigned MAX_DIM = ludf_pkg::MAX_DIM_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ludf_stream_if.sink   in_req,
    ludf_stream_if.sink   cfg_req,
    ludf_stream_if.source out_req
);
    import ludf_pkg::*;

    localparam int unsigned DW     = $clog2(MAX_DIM);
    localparam int unsigned AW     = 2 * DW;
    localparam int unsigned DEPTH  = 1 << AW;
    localparam int unsigned CW     = $clog2(MAX_DIM + 1);

    typedef enum logic [9:0] {
        S_LOAD  = 10'b00_0000_0001,
        S_ENTRY = 10'b00_0000_0010,
        S_RD    = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_ACC   = 10'b00_0001_0000,
        S_FIN   = 10'b00_0010_0000,
        S_DIV   = 10'b00_0100_0000,
        S_ORD   = 10'b00_1000_0000,
        S_OUT   = 10'b01_0000_0000,
        S_OWAIT = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    logic [SIZE_W-1:0] r_size;
    logic [CW-1:0]     w_n;
    logic [CW-1:0]     r_row, r_col;
    logic [CW-1:0]     r_i, r_k, r_j;
    logic              r_upper;   // computing upper (1) or lower (0) entry
    logic              r_fault;
    logic signed [DATA_W-1:0] r_acc, r_a, r_l, r_u, r_num;
    logic signed [63:0] r_prod;

    logic signed [DATA_W-1:0] m_store [DEPTH];
    logic signed [DATA_W-1:0] l_store [DEPTH];
    logic signed [DATA_W-1:0] u_store [DEPTH];
    logic signed [DATA_W-1:0] r_ld, r_ud;
    logic [AW-1:0] w_la, w_ua;

    t_div_cmd w_dcmd;
    t_div_rsp w_drsp;
    t_out_req r_out;
    logic     r_ovalid;

    ludf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_dcmd), .o_rsp(w_drsp));

    always_comb begin
        if (r_size == '0)                      w_n = CW'(1);
        else if ({1'b0, r_size} > 5'(MAX_DIM)) w_n = CW'(MAX_DIM);
        else                                   w_n = CW'(r_size);
    end

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        addr = {r[DW-1:0], c[DW-1:0]};
    endfunction

    // operand addresses: upper entry (i,k): L[i][j]*U[j][k]; lower (k,i): L[k][j]*U[j][i]
    always_comb begin
        w_la = r_upper ? addr(r_i, r_j) : addr(r_k, r_j);
        w_ua = r_upper ? addr(r_j, r_k) : addr(r_j, r_i);
        if (r_state == S_ORD || r_state == S_OUT) begin
            w_la = addr(r_row, r_col);
            w_ua = addr(r_row, r_col);
        end
    end

    assign in_req.ready  = (r_state == S_LOAD) && !cfg_req.valid;
    assign cfg_req.ready = (r_state == S_LOAD);
    assign w_dcmd.start  = (r_state == S_FIN) && !r_upper;
    assign w_dcmd.num    = sat32(66'(r_a) - 66'(r_acc));
    assign w_dcmd.den    = r_num;

    logic signed [DATA_W-1:0] w_sum, w_pq;
    logic signed [65:0] w_psh;
    always_comb begin
        w_psh = 66'(r_prod >>> 16);
        w_pq  = sat32(w_psh);
        w_sum = sat32(66'(r_acc) + 66'(w_pq));
    end

    logic w_last;
    assign w_last = (r_row == w_n - 1'b1) && (r_col == w_n - 1'b1);

    // output register free: take the next position
    logic w_emit;
    assign w_emit = (r_state == S_OUT) && (!r_ovalid || out_req.ready);

    always_ff @(posedge i_clk) begin
        r_ld <= l_store[w_la];
        r_ud <= u_store[w_ua];
        if (in_req.valid && in_req.ready)
            m_store[addr(r_row, r_col)] <= in_req.payload.element_value;
        if (r_state == S_ENTRY)
            r_a <= m_store[r_upper ? addr(r_i, r_k) : addr(r_k, r_i)];
        if (r_state == S_ENTRY)
            r_num <= u_store[addr(r_i, r_i)];
        if (r_state == S_MUL) r_prod <= 64'(r_ld) * 64'(r_ud);
        if (r_state == S_FIN && r_upper)
            u_store[addr(r_i, r_k)] <= sat32(66'(r_a) - 66'(r_acc));
        if (r_state == S_DIV && w_drsp.done)
            l_store[addr(r_k, r_i)] <= (r_num == '0) ? '0 : w_drsp.quot;
        if (w_emit) begin
            r_out.row_index    <= IDX_W'(r_row);
            r_out.column_index <= IDX_W'(r_col);
            r_out.lower_value  <= (r_col > r_row) ? '0 : (r_col == r_row) ? Q_ONE : r_ld;
            r_out.upper_value  <= (r_col < r_row) ? '0 : r_ud;
            r_out.pivot_fault  <= r_fault;
            r_out.last_result  <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_size   <= SIZE_W'(SIZE_RESET);
            r_row    <= '0;
            r_col    <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_upper  <= 1'b1;
            r_fault  <= 1'b0;
            r_acc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) r_ovalid <= 1'b1;
            else if (out_req.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (cfg_req.valid) begin
                        r_size <= cfg_req.payload;
                        r_row  <= '0;
                        r_col  <= '0;
                    end else if (in_req.valid) begin
                        if (r_col == w_n - 1'b1) begin
                            r_col <= '0;
                            if (r_row == w_n - 1'b1) begin
                                r_row   <= '0;
                                r_i     <= '0;
                                r_k     <= '0;
                                r_j     <= '0;
                                r_upper <= 1'b1;
                                r_fault <= 1'b0;
                                r_acc   <= '0;
                                r_state <= S_ENTRY;
                            end else begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_ENTRY: begin
                    r_acc <= '0;
                    r_j   <= '0;
                    r_state <= (r_i == '0) ? S_FIN : S_RD;
                end
                S_RD:  r_state <= S_MUL;
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= w_sum;
                    if (r_j + 1'b1 == r_i) r_state <= S_FIN;
                    else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN: begin
                    if (r_upper) begin
                        if (r_k == w_n - 1'b1) begin
                            if (r_i == w_n - 1'b1) r_state <= S_ORD;
                            else begin
                                r_upper <= 1'b0;
                                r_k     <= r_i + 1'b1;
                                r_state <= S_ENTRY;
                            end
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ENTRY;
                        end
                    end else begin
                        if (r_num == '0) r_fault <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        if (r_k == w_n - 1'b1) begin
                            r_i     <= r_i + 1'b1;
                            r_k     <= r_i + 1'b1;
                            r_upper <= 1'b1;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                        r_state <= S_ENTRY;
                    end
                end
                S_ORD: r_state <= S_OUT;
                S_OUT: begin
                    if (w_emit) begin
                        if (w_last) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_OWAIT;
                        end else begin
                            if (r_col == w_n - 1'b1) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                            r_state <= S_ORD;
                        end
                    end
                end
                S_OWAIT: begin
                    if (!r_ovalid || out_req.ready) r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign out_req.valid   = r_ovalid;
    assign out_req.payload = r_out;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ludf_pkg::*;

    typedef logic signed [DATA_W-1:0] t_q;

    localparam int unsigned SZ_MAX   = MAX_DIM_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ludf_stream_if #(.T(t_in_req))           in_req ();
    ludf_stream_if #(.T(logic [SIZE_W-1:0])) cfg_req ();
    ludf_stream_if #(.T(t_out_req))          out_req ();

    lu_doolittle_factorizer_unit #(.MAX_DIM(SZ_MAX)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_req  (in_req.sink),
        .cfg_req (cfg_req.sink),
        .out_req (out_req.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    t_q          mat_a [SZ_MAX*SZ_MAX];
    t_q          fac_l [SZ_MAX*SZ_MAX];
    t_q          fac_u [SZ_MAX*SZ_MAX];
    int unsigned loaded;
    logic [SIZE_W-1:0] size_reg;
    logic        pivot_zero;

    t_out_req    lu_expected [$];
    int          err_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic t_q sat(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648) return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    function automatic t_q q_mul(input t_q a, input t_q b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return sat(p >>> 16);
    endfunction

    function automatic t_q q_div(input t_q a, input t_q b);
        logic signed [65:0] num;
        if (b == 0) begin
            pivot_zero = 1'b1;
            return '0;
        end
        num = 66'(a) * 66'sd65536;
        return sat(num / 66'(b));
    endfunction

    function automatic int unsigned active_dim();
        if (size_reg == 0) return 1;
        if (size_reg > SZ_MAX) return SZ_MAX;
        return size_reg;
    endfunction

    task automatic factor_matrix(input int unsigned n);
        t_q acc;
        pivot_zero = 1'b0;
        for (int i = 0; i < n; i++) begin
            for (int k = i; k < n; k++) begin
                acc = '0;
                for (int j = 0; j < i; j++)
                    acc = sat(66'(acc) + 66'(q_mul(fac_l[i*SZ_MAX+j], fac_u[j*SZ_MAX+k])));
                fac_u[i*SZ_MAX+k] = sat(66'(mat_a[i*SZ_MAX+k]) - 66'(acc));
            end
            fac_l[i*SZ_MAX+i] = Q_ONE;
            for (int k = i + 1; k < n; k++) begin
                acc = '0;
                for (int j = 0; j < i; j++)
                    acc = sat(66'(acc) + 66'(q_mul(fac_l[k*SZ_MAX+j], fac_u[j*SZ_MAX+i])));
                fac_l[k*SZ_MAX+i] = q_div(sat(66'(mat_a[k*SZ_MAX+i]) - 66'(acc)),
                                          fac_u[i*SZ_MAX+i]);
            end
        end
    endtask

    task automatic predict_element(input t_q v);
        int unsigned n;
        t_out_req    r;
        n = active_dim();
        if (loaded >= n*n) loaded = 0;
        mat_a[(loaded/n)*SZ_MAX + loaded%n] = v;
        loaded++;
        if (loaded == n*n) begin
            loaded = 0;
            factor_matrix(n);
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    r.row_index    = i[IDX_W-1:0];
                    r.column_index = j[IDX_W-1:0];
                    r.lower_value  = (j > i) ? t_q'(0) : (j == i) ? Q_ONE
                                   : fac_l[i*SZ_MAX+j];
                    r.upper_value  = (j < i) ? t_q'(0) : fac_u[i*SZ_MAX+j];
                    r.pivot_fault  = pivot_zero;
                    r.last_result  = (i == n-1 && j == n-1);
                    lu_expected = {lu_expected, r};
                end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_req.valid && out_req.ready) begin
            if (lu_expected.size() == 0) begin
                $display("%0t unexpected result: got %p", $time, out_req.payload);
                err_count++;
            end else begin
                t_out_req e;
                e = lu_expected.pop_front();
                if (out_req.payload !== e) begin
                    $display("%0t mismatch: expected %p, actual %p",
                             $time, e, out_req.payload);
                    err_count++;
                end
            end
        end
    end

    always @(negedge i_clk)
        out_req.ready <= ($urandom_range(99) >= recv_stall_pct);

    // valid stays up after a request so that requests can follow back to back
    task automatic send_element(input t_q v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_req.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_req.valid   <= 1'b1;
        in_req.payload <= v;
        do @(posedge i_clk); while (!in_req.ready);
        predict_element(v);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_req.valid <= 1'b0;
        while (lu_expected.size() != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);  // covers a factorization with no result
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] s);
        drain();
        cfg_req.valid   <= 1'b1;
        cfg_req.payload <= s;
        do @(posedge i_clk); while (!cfg_req.ready);
        size_reg = s;
        loaded   = 0;
        @(negedge i_clk);
        cfg_req.valid <= 1'b0;
    endtask

    function automatic t_q rand_elem(input int mode);
        case (mode)
            0: return $urandom();
            1: return t_q'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            default: return t_q'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    // directed rows: size setting, then values; 1x1 results read off at a glance
    typedef struct {
        logic [SIZE_W-1:0] size;
        t_q                v;
        logic              known;
        t_q                up;
        logic              flt;
    } t_row;

    t_row dir_rows [] = '{
        '{4'd1, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b0},
        '{4'd1, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b0},
        '{4'd0, 32'sh0000_0000, 1'b1, 32'sh0000_0000, 1'b0},
        '{4'd15, 32'sh0001_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh0000_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh7FFF_FFFF, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh8000_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh0001_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh0002_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'shFFFF_0000, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh0000_0001, 1'b0, 0, 1'b0},
        '{4'd2, 32'sh0003_8000, 1'b0, 0, 1'b0}
    };

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned n;
        int          mode;
        logic [SIZE_W-1:0] cur;
        t_q          fill;
        in_req.valid    = 1'b0;
        in_req.payload  = '0;
        cfg_req.valid   = 1'b0;
        cfg_req.payload = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        err_count       = 0;
        loaded          = 0;
        pivot_zero      = 1'b0;
        size_reg        = SIZE_W'(SIZE_RESET);
        foreach (mat_a[i]) begin
            mat_a[i] = '0; fac_l[i] = '0; fac_u[i] = '0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size is full dimension; partial load then restart via size write
        for (int i = 0; i < 5; i++) send_element(rand_elem(0));

        cur = '1;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].size != cur) begin
                cur = dir_rows[r].size;
                write_size(cur);
            end
            if (dir_rows[r].size == 4'd15) begin
                // oversize acts as full size: 64 elements of an identity matrix, from one table row
                for (int i = 0; i < 64; i++)
                    send_element((i % 9 == 0) ? Q_ONE : t_q'(0));
                continue;
            end
            if (dir_rows[r].known) begin
                t_out_req e;
                e.row_index = '0; e.column_index = '0;
                e.lower_value = Q_ONE; e.upper_value = dir_rows[r].up;
                e.pivot_fault = dir_rows[r].flt; e.last_result = 1'b1;
                send_element(dir_rows[r].v);
                if (lu_expected.size() == 0 || lu_expected[$] !== e) begin
                    $display("%0t table mismatch: expected %p, actual %p", $time, e,
                             lu_expected.size() ? lu_expected[$] : e);
                    err_count++;
                end
            end else begin
                send_element(dir_rows[r].v);
            end
        end

        // random part, in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            fill = 0;
            while (fill < 10) begin
                cur = 4'($urandom_range(1, 4));
                write_size(cur);
                n = active_dim();
                mode = $urandom_range(0, 2);
                for (int i = 0; i < n*n; i++) begin
                    t_q v;
                    v = rand_elem(mode);
                    if (mode != 0 && $urandom_range(9) == 0) v = '0;
                    send_element(v);
                end
                fill += n*n;
            end
        end

        drain();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
